>>> sv/esc_pkg.sv
package esc_pkg;

  localparam int unsigned DivSteps = 32;

  localparam logic [31:0] PresOffset  = 32'd64000;
  localparam logic [31:0] PresBase    = 32'd32768;
  localparam logic [31:0] PresRawBase = 32'd1048576;
  localparam logic [31:0] PresScale   = 32'd3125;
  localparam logic [31:0] HumOffset   = 32'd76800;
  localparam logic [31:0] HumRound    = 32'd16384;
  localparam logic [31:0] HumBase     = 32'd2097152;
  localparam logic [31:0] HumRound2   = 32'd8192;
  localparam logic [31:0] HumClamp    = 32'd419430400;
  localparam logic [31:0] TempRound   = 32'd128;
  localparam logic [16:0] HumMax      = 17'd102400;

  localparam logic [2:0] RegTempCal   = 3'd0;
  localparam logic [2:0] RegPresLow   = 3'd1;
  localparam logic [2:0] RegPresHigh  = 3'd2;
  localparam logic [2:0] RegPresHum   = 3'd3;
  localparam logic [2:0] RegHumCal    = 3'd4;

  typedef struct packed {
    logic [31:0] t1, t2, t3;
    logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
  } cal_t;

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] fine;
    logic        divz;
    logic        dbl;
    logic [31:0] hum_a;
  } side_t;

  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] mul(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] r;
    r = a * b;
    return r;
  endfunction

  function automatic logic [31:0] sext16(input logic [15:0] x);
    return {{16{x[15]}}, x};
  endfunction

  function automatic logic [31:0] sext12(input logic [11:0] x);
    return {{20{x[11]}}, x};
  endfunction

  function automatic logic [31:0] sext8(input logic [7:0] x);
    return {{24{x[7]}}, x};
  endfunction

endpackage

>>> sv/esc_front.sv
module esc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  esc_pkg::cal_t     cal_i,
  input  logic              valid_i,
  input  logic [19:0]       raw_temp_i,
  input  logic [19:0]       raw_pres_i,
  input  logic [15:0]       raw_hum_i,
  output logic              valid_o,
  output logic [31:0]       num_o,
  output logic [31:0]       den_o,
  output esc_pkg::side_t    side_o
);
  import esc_pkg::*;

  logic [11:0] v_q;

  logic [31:0] at1_q, ap1_q, ah1_q;
  logic [31:0] m1_2_q, m2_2_q, ap2_q, ah2_q;
  logic [31:0] a1_3_q, m3_3_q, ap3_q, ah3_q;
  logic [31:0] fine4_q, ap4_q, ah4_q;
  logic [31:0] temp5_q, fine5_q, pa5_q, pd5_q, ha5_q, ap5_q, ah5_q;
  logic [31:0] temp6_q, fine6_q, pdd6_q, pa5m6_q, p2a6_q, hh5_6_q, hh6_6_q, hh3_6_q;
  logic [31:0] ap6_q, ah6_q;
  logic [31:0] temp7_q, fine7_q, pb6_7_q, pc7_q, dh7_q, b6_7_q, x3_7_q, pa5m7_q, p2a7_q;
  logic [31:0] ap7_q;
  logic [31:0] temp8_q, fine8_q, pb8_q, pa2_8_q, hb8_q, dh8_q, ap8_q;
  logic [31:0] temp9_q, fine9_q, pa3_9_q, hb2_9_q, pnp9_q, dh9_q;
  logic [31:0] temp10_q, fine10_q, dv10_q, pn10_q, hb3_10_q, dh10_q;
  logic [31:0] temp11_q, fine11_q, dv11_q, num11_q, hb4_11_q, dh11_q;
  logic        divz11_q, dbl11_q;
  logic [31:0] num12_q, den12_q;
  side_t       side12_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[10:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      at1_q <= 32'(raw_temp_i);
      ap1_q <= 32'(raw_pres_i);
      ah1_q <= 32'(raw_hum_i);

      m1_2_q <= mul((at1_q >> 3) - (cal_i.t1 << 1), cal_i.t2);
      m2_2_q <= mul((at1_q >> 4) - cal_i.t1, (at1_q >> 4) - cal_i.t1);
      ap2_q  <= ap1_q;
      ah2_q  <= ah1_q;

      a1_3_q <= asr(m1_2_q, 11);
      m3_3_q <= mul(asr(m2_2_q, 12), cal_i.t3);
      ap3_q  <= ap2_q;
      ah3_q  <= ah2_q;

      fine4_q <= a1_3_q + asr(m3_3_q, 14);
      ap4_q   <= ap3_q;
      ah4_q   <= ah3_q;

      temp5_q <= asr((fine4_q << 2) + fine4_q + TempRound, 8);
      fine5_q <= fine4_q;
      pa5_q   <= asr(fine4_q, 1) - PresOffset;
      pd5_q   <= asr(asr(fine4_q, 1) - PresOffset, 2);
      ha5_q   <= fine4_q - HumOffset;
      ap5_q   <= ap4_q;
      ah5_q   <= ah4_q;

      temp6_q  <= temp5_q;
      fine6_q  <= fine5_q;
      pdd6_q   <= mul(pd5_q, pd5_q);
      pa5m6_q  <= mul(pa5_q, cal_i.p5);
      p2a6_q   <= mul(cal_i.p2, pa5_q);
      hh5_6_q  <= mul(cal_i.h5, ha5_q);
      hh6_6_q  <= mul(ha5_q, cal_i.h6);
      hh3_6_q  <= mul(ha5_q, cal_i.h3);
      ap6_q    <= ap5_q;
      ah6_q    <= ah5_q;

      temp7_q  <= temp6_q;
      fine7_q  <= fine6_q;
      pb6_7_q  <= mul(asr(pdd6_q, 11), cal_i.p6);
      pc7_q    <= mul(cal_i.p3, asr(pdd6_q, 13));
      dh7_q    <= asr((ah6_q << 14) - (cal_i.h4 << 20) - hh5_6_q + HumRound, 15);
      b6_7_q   <= asr(hh6_6_q, 10);
      x3_7_q   <= asr(hh3_6_q, 11) + PresBase;
      pa5m7_q  <= pa5m6_q;
      p2a7_q   <= p2a6_q;
      ap7_q    <= ap6_q;

      temp8_q  <= temp7_q;
      fine8_q  <= fine7_q;
      pb8_q    <= asr(pb6_7_q + (pa5m7_q << 1), 2) + (cal_i.p4 << 16);
      pa2_8_q  <= asr(asr(pc7_q, 3) + asr(p2a7_q, 1), 18);
      hb8_q    <= mul(b6_7_q, x3_7_q);
      dh8_q    <= dh7_q;
      ap8_q    <= ap7_q;

      temp9_q  <= temp8_q;
      fine9_q  <= fine8_q;
      pa3_9_q  <= mul(PresBase + pa2_8_q, cal_i.p1);
      hb2_9_q  <= asr(hb8_q, 10) + HumBase;
      pnp9_q   <= (PresRawBase - ap8_q) - asr(pb8_q, 12);
      dh9_q    <= dh8_q;

      temp10_q <= temp9_q;
      fine10_q <= fine9_q;
      dv10_q   <= asr(pa3_9_q, 15);
      pn10_q   <= mul(pnp9_q, PresScale);
      hb3_10_q <= mul(hb2_9_q, cal_i.h2);
      dh10_q   <= dh9_q;

      temp11_q <= temp10_q;
      fine11_q <= fine10_q;
      dv11_q   <= dv10_q;
      divz11_q <= (dv10_q == '0);
      dbl11_q  <= pn10_q[31];
      num11_q  <= pn10_q[31] ? pn10_q : (pn10_q << 1);
      hb4_11_q <= asr(hb3_10_q + HumRound2, 14);
      dh11_q   <= dh10_q;

      num12_q        <= num11_q;
      den12_q        <= dv11_q;
      side12_q.temp  <= temp11_q;
      side12_q.fine  <= fine11_q;
      side12_q.divz  <= divz11_q;
      side12_q.dbl   <= dbl11_q;
      side12_q.hum_a <= mul(dh11_q, hb4_11_q);
    end
  end

  assign valid_o = v_q[11];
  assign num_o   = num12_q;
  assign den_o   = den12_q;
  assign side_o  = side12_q;

endmodule

>>> sv/esc_div.sv
module esc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [31:0]       num_i,
  input  logic [31:0]       den_i,
  input  esc_pkg::side_t    side_i,
  output logic              valid_o,
  output logic [31:0]       quot_o,
  output esc_pkg::side_t    side_o
);
  import esc_pkg::*;

  logic        v_q [DivSteps];
  logic [31:0] r_q [DivSteps];
  logic [31:0] n_q [DivSteps];
  logic [31:0] q_q [DivSteps];
  logic [31:0] d_q [DivSteps];
  side_t       s_q [DivSteps];

  for (genvar i = 0; i < DivSteps; i++) begin : g_step
    logic        v_in;
    logic [31:0] r_in, n_in, q_in, d_in;
    side_t       s_in;
    logic [32:0] trial, diff;

    if (i == 0) begin : g_first
      assign v_in = valid_i;
      assign r_in = '0;
      assign n_in = num_i;
      assign q_in = '0;
      assign d_in = den_i;
      assign s_in = side_i;
    end else begin : g_next
      assign v_in = v_q[i-1];
      assign r_in = r_q[i-1];
      assign n_in = n_q[i-1];
      assign q_in = q_q[i-1];
      assign d_in = d_q[i-1];
      assign s_in = s_q[i-1];
    end

    assign trial = {r_in, n_in[31]};
    assign diff  = trial - {1'b0, d_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[i] <= diff[32] ? trial[31:0] : diff[31:0];
        n_q[i] <= n_in << 1;
        q_q[i] <= {q_in[30:0], ~diff[32]};
        d_q[i] <= d_in;
        s_q[i] <= s_in;
      end
    end
  end

  assign valid_o = v_q[DivSteps-1];
  assign quot_o  = q_q[DivSteps-1];
  assign side_o  = s_q[DivSteps-1];

endmodule

>>> sv/esc_back.sv
module esc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  esc_pkg::cal_t      cal_i,
  input  logic               valid_i,
  input  logic [31:0]        quot_i,
  input  esc_pkg::side_t     side_i,
  output logic               valid_o,
  output logic [31:0]        temp_o,
  output logic [31:0]        fine_o,
  output logic [31:0]        pres_o,
  output logic               divz_o,
  output logic [16:0]        hum_o
);
  import esc_pkg::*;

  logic [3:0]  v_q;
  side_t       s1_q, s2_q, s3_q;
  logic [31:0] p1_q, hq1_q;
  logic [31:0] p2_q, pp2_q, pm8_2_q, hqq2_q;
  logic [31:0] p3_q, pa3_q, pbb3_q, ht3_q;
  logic [31:0] temp4_q, fine4_q, pres4_q;
  logic        divz4_q;
  logic [16:0] hum4_q;

  logic [31:0] hum_sub;
  logic [31:0] hum_clamped;

  always_comb begin
    hum_sub = s3_q.hum_a - asr(ht3_q, 4);
    if (hum_sub[31]) begin
      hum_clamped = '0;
    end else if (hum_sub > HumClamp) begin
      hum_clamped = HumClamp;
    end else begin
      hum_clamped = hum_sub;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q  <= side_i;
      p1_q  <= side_i.dbl ? (quot_i << 1) : quot_i;
      hq1_q <= asr(side_i.hum_a, 15);

      s2_q    <= s1_q;
      p2_q    <= p1_q;
      pp2_q   <= mul(p1_q >> 3, p1_q >> 3);
      pm8_2_q <= mul(p1_q >> 2, cal_i.p8);
      hqq2_q  <= mul(hq1_q, hq1_q);

      s3_q   <= s2_q;
      p3_q   <= p2_q;
      pa3_q  <= mul(cal_i.p9, pp2_q >> 13);
      pbb3_q <= asr(pm8_2_q, 13);
      ht3_q  <= mul(asr(hqq2_q, 7), cal_i.h1);

      temp4_q <= s3_q.temp;
      fine4_q <= s3_q.fine;
      divz4_q <= s3_q.divz;
      pres4_q <= s3_q.divz ? '0 : p3_q + asr(asr(pa3_q, 12) + pbb3_q + cal_i.p7, 4);
      hum4_q  <= hum_clamped[28:12];
    end
  end

  assign valid_o = v_q[3];
  assign temp_o  = temp4_q;
  assign fine_o  = fine4_q;
  assign pres_o  = pres4_q;
  assign divz_o  = divz4_q;
  assign hum_o   = hum4_q;

endmodule

>>> sv/env_sensor_compensation.sv
// Channel  Handshake                Payload
// in       in_valid_i / in_ready_o   raw_temp_i, raw_pres_i, raw_hum_i
// out      out_valid_o / out_ready_i temp_centideg_o, fine_temp_o, pres_pa_o,
//                                    pres_div_zero_o, hum_q10_o
// cfg      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// One request enters per cycle while the output is not stalled.
// The pipeline is made of 12 front stages, a 32-stage radix-2 divider and 4 back stages.
// Reset clears the valid bits and the calibration registers to zero.
// A stalled output holds the whole pipeline, so nothing is lost or repeated.
module env_sensor_compensation (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [63:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [19:0]        raw_temp_i,
  input  logic [19:0]        raw_pres_i,
  input  logic [15:0]        raw_hum_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] temp_centideg_o,
  output logic signed [31:0] fine_temp_o,
  output logic [31:0]        pres_pa_o,
  output logic               pres_div_zero_o,
  output logic [16:0]        hum_q10_o
);
  import esc_pkg::*;

  logic [47:0] temp_cal_q;
  logic [63:0] pres_low_q, pres_high_q;
  logic [47:0] pres_hum_q;
  logic [31:0] hum_cal_q;

  cal_t        cal;
  logic        en;
  logic        f_valid, d_valid;
  logic [31:0] f_num, f_den, d_quot;
  side_t       f_side, d_side;
  logic [31:0] temp_w, fine_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_cal_q  <= '0;
      pres_low_q  <= '0;
      pres_high_q <= '0;
      pres_hum_q  <= '0;
      hum_cal_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegTempCal:  temp_cal_q  <= cfg_wdata_i[47:0];
        RegPresLow:  pres_low_q  <= cfg_wdata_i;
        RegPresHigh: pres_high_q <= cfg_wdata_i;
        RegPresHum:  pres_hum_q  <= cfg_wdata_i[47:0];
        RegHumCal:   hum_cal_q   <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cal.t1 = 32'(temp_cal_q[15:0]);
    cal.t2 = sext16(temp_cal_q[31:16]);
    cal.t3 = sext16(temp_cal_q[47:32]);
    cal.p1 = 32'(pres_low_q[15:0]);
    cal.p2 = sext16(pres_low_q[31:16]);
    cal.p3 = sext16(pres_low_q[47:32]);
    cal.p4 = sext16(pres_low_q[63:48]);
    cal.p5 = sext16(pres_high_q[15:0]);
    cal.p6 = sext16(pres_high_q[31:16]);
    cal.p7 = sext16(pres_high_q[47:32]);
    cal.p8 = sext16(pres_high_q[63:48]);
    cal.p9 = sext16(pres_hum_q[15:0]);
    cal.h1 = 32'(pres_hum_q[23:16]);
    cal.h2 = sext16(pres_hum_q[39:24]);
    cal.h3 = 32'(pres_hum_q[47:40]);
    cal.h4 = sext12(hum_cal_q[11:0]);
    cal.h5 = sext12(hum_cal_q[23:12]);
    cal.h6 = sext8(hum_cal_q[31:24]);
  end

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  esc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .cal_i      (cal),
    .valid_i    (in_valid_i),
    .raw_temp_i (raw_temp_i),
    .raw_pres_i (raw_pres_i),
    .raw_hum_i  (raw_hum_i),
    .valid_o    (f_valid),
    .num_o      (f_num),
    .den_o      (f_den),
    .side_o     (f_side)
  );

  esc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .num_i   (f_num),
    .den_i   (f_den),
    .side_i  (f_side),
    .valid_o (d_valid),
    .quot_o  (d_quot),
    .side_o  (d_side)
  );

  esc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cal_i   (cal),
    .valid_i (d_valid),
    .quot_i  (d_quot),
    .side_i  (d_side),
    .valid_o (out_valid_o),
    .temp_o  (temp_w),
    .fine_o  (fine_w),
    .pres_o  (pres_pa_o),
    .divz_o  (pres_div_zero_o),
    .hum_o   (hum_q10_o)
  );

  assign temp_centideg_o = $signed(temp_w);
  assign fine_temp_o     = $signed(fine_w);

  a_divz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pres_div_zero_o |-> pres_pa_o == '0)
    else $error("pressure not forced to zero on a zero divisor");

  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hum_q10_o <= HumMax)
    else $error("humidity above clamp");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pres_pa_o) && $stable(hum_q10_o))
    else $error("stalled result changed");

endmodule
